@@ rtl/pwfe_pkg.sv @@
// Shared types and constants for the pulse-width frame encoder.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package pwfe_pkg;

  localparam int DUR_W              = 16;
  localparam int BYTE_W             = 8;
  localparam int PREAMBLE_PAIRS_DEF = 9;
  localparam int DATA_HALVES        = 18;   // eight bit pairs and one parity pair

  // Configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_SHORT = 2'd0;
  localparam logic [1:0] REG_LONG  = 2'd1;
  localparam logic [1:0] REG_END   = 2'd2;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Command queue and output queue geometry
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              parity;
    logic              first_of_frame;
    logic              last_of_frame;
  } cmd_t;

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             last_of_run;
    logic             frame_end;
  } res_t;

  typedef struct packed {
    logic [DUR_W-1:0] short_duration;
    logic [DUR_W-1:0] long_duration;
    logic [DUR_W-1:0] end_duration;
  } cfg_t;

endpackage

@@ rtl/pwfe_front.sv @@
// Front end: accepts input bytes, computes parity and queues a command.
// Depends on pwfe_pkg.
`timescale 1ns / 1ps

module pwfe_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [pwfe_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                             in_first_of_frame,
  input  logic                             in_last_of_frame,
  output logic                             cmd_valid,
  output pwfe_pkg::cmd_t                   cmd_data,
  input  logic                             cmd_pop
);

  pwfe_pkg::cmd_t                      mem_r [pwfe_pkg::QUEUE_DEPTH];
  logic [pwfe_pkg::QUEUE_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [pwfe_pkg::QUEUE_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [pwfe_pkg::QUEUE_AW:0]         cnt_r, cnt_nxt;
  logic                                do_push, do_pop;
  pwfe_pkg::cmd_t                      new_cmd;

  assign full      = (cnt_r == (pwfe_pkg::QUEUE_AW+1)'(pwfe_pkg::QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    new_cmd.data_byte      = in_data_byte;
    new_cmd.parity         = ^in_data_byte;
    new_cmd.first_of_frame = in_first_of_frame;
    new_cmd.last_of_frame  = in_last_of_frame;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (pwfe_pkg::QUEUE_AW)'(do_push);
    rd_ptr_nxt = rd_ptr_r + (pwfe_pkg::QUEUE_AW)'(do_pop);
    cnt_nxt    = cnt_r + (pwfe_pkg::QUEUE_AW+1)'(do_push)
                       - (pwfe_pkg::QUEUE_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

@@ rtl/pwfe_back.sv @@
// Back end: sequences one command into its run of durations, one per cycle
// if the small output queue holding results has room. Depends on pwfe_pkg.
`timescale 1ns / 1ps

module pwfe_back #(
  parameter int PREAMBLE_PAIRS = pwfe_pkg::PREAMBLE_PAIRS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pwfe_pkg::cfg_t               cfg,
  input  logic                         cmd_valid,
  input  pwfe_pkg::cmd_t               cmd_data,
  output logic                         cmd_pop,
  output logic                         empty,
  input  logic                         pop,
  output pwfe_pkg::res_t               res
);

  localparam int PRE_HALVES = 2 * PREAMBLE_PAIRS;
  localparam int CNT_MAX    = (PRE_HALVES > pwfe_pkg::DATA_HALVES) ? PRE_HALVES
                                                                   : pwfe_pkg::DATA_HALVES;
  localparam int CNT_W      = $clog2(CNT_MAX);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_PRE   = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_END   = 2'd3;

  logic                 busy_r, busy_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  pwfe_pkg::cmd_t       cur_r, cur_nxt;

  pwfe_pkg::res_t                  omem_r [pwfe_pkg::QUEUE_DEPTH];
  logic [pwfe_pkg::QUEUE_AW-1:0]   owr_r, owr_nxt;
  logic [pwfe_pkg::QUEUE_AW-1:0]   ord_r, ord_nxt;
  logic [pwfe_pkg::QUEUE_AW:0]     ocnt_r, ocnt_nxt;

  logic                 emit, final_step, load, do_pop, bit_val;
  logic [8:0]           bits9;
  pwfe_pkg::res_t       out_item;

  assign emit  = busy_r && (ocnt_r != (pwfe_pkg::QUEUE_AW+1)'(pwfe_pkg::QUEUE_DEPTH));
  assign bits9 = {cur_r.parity, cur_r.data_byte};
  assign bit_val = bits9[cnt_r[4:1]];

  always_comb begin
    final_step = 1'b0;
    if (phase_r == PH_END) begin
      final_step = 1'b1;
    end else if (phase_r == PH_DATA &&
                 cnt_r == CNT_W'(pwfe_pkg::DATA_HALVES - 1) && !cur_r.last_of_frame) begin
      final_step = 1'b1;
    end
  end

  assign load    = cmd_valid && (!busy_r || (emit && final_step));
  assign cmd_pop = load;

  // Select the duration for the current step
  always_comb begin
    out_item.last_of_run = final_step;
    out_item.frame_end   = (phase_r == PH_END);
    unique case (phase_r)
      PH_START: out_item.duration = cfg.long_duration;
      PH_PRE:   out_item.duration = cfg.short_duration;
      PH_DATA:  out_item.duration = bit_val ? cfg.long_duration : cfg.short_duration;
      PH_END:   out_item.duration = cfg.end_duration;
      default:  out_item.duration = cfg.short_duration;
    endcase
  end

  // Step sequencer
  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    if (emit) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      unique case (phase_r)
        PH_START: begin
          phase_nxt = PH_PRE;
          cnt_nxt   = '0;
        end
        PH_PRE: begin
          if (cnt_r == CNT_W'(PRE_HALVES - 1)) begin
            phase_nxt = PH_DATA;
            cnt_nxt   = '0;
          end
        end
        PH_DATA: begin
          if (cnt_r == CNT_W'(pwfe_pkg::DATA_HALVES - 1)) begin
            phase_nxt = PH_END;
            cnt_nxt   = '0;
          end
        end
        PH_END: begin
          cnt_nxt = '0;
        end
        default: begin
          cnt_nxt = '0;
        end
      endcase
      if (final_step) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt  = 1'b1;
      cur_nxt   = cmd_data;
      cnt_nxt   = '0;
      phase_nxt = cmd_data.first_of_frame ? PH_START : PH_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_DATA;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Output queue
  assign empty  = (ocnt_r == '0);
  assign do_pop = pop && !empty;
  assign res    = omem_r[ord_r];

  always_comb begin
    owr_nxt  = owr_r + (pwfe_pkg::QUEUE_AW)'(emit);
    ord_nxt  = ord_r + (pwfe_pkg::QUEUE_AW)'(do_pop);
    ocnt_nxt = ocnt_r + (pwfe_pkg::QUEUE_AW+1)'(emit)
                      - (pwfe_pkg::QUEUE_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owr_r  <= owr_nxt;
      ord_r  <= ord_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      omem_r[owr_r] <= out_item;
    end
  end

endmodule

@@ rtl/pulse_width_frame_encoder.sv @@
// Pulse-width frame encoder: one duration is queued per cycle while the output queue has
// room; a plain byte gives 18 durations, a frame-opening byte 1 + 2*PREAMBLE_PAIRS more,
// a frame-closing byte one more; the back-end sequencer's output writes set that rate.
// An item's first duration passes the command queue, sequencer and output queue.
// Reset (rst_n low, synchronous) empties both queues, idles the sequencer and loads
// the duration registers with 50, 100 and 400. Depends on pwfe_pkg, pwfe_front, pwfe_back.
`timescale 1ns / 1ps

module pulse_width_frame_encoder #(
  parameter int PREAMBLE_PAIRS = pwfe_pkg::PREAMBLE_PAIRS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             push,
  output logic                             full,
  input  logic [pwfe_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                             in_first_of_frame,
  input  logic                             in_last_of_frame,
  // result channel
  output logic                             empty,
  input  logic                             pop,
  output logic [pwfe_pkg::DUR_W-1:0]       out_duration,
  output logic                             out_last_of_run,
  output logic                             out_frame_end,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pwfe_pkg::APB_AW-1:0]      paddr,
  input  logic [pwfe_pkg::APB_DW-1:0]      pwdata,
  output logic [pwfe_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  pwfe_pkg::cfg_t   cfg_r, cfg_nxt;
  logic             cfg_wr;
  logic [1:0]       reg_idx;
  logic             cmd_valid, cmd_pop;
  pwfe_pkg::cmd_t   cmd_data;
  pwfe_pkg::res_t   res;

  // Configuration registers: write on the access phase, ignore unknown indexes
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        pwfe_pkg::REG_SHORT: cfg_nxt.short_duration = pwdata[pwfe_pkg::DUR_W-1:0];
        pwfe_pkg::REG_LONG:  cfg_nxt.long_duration  = pwdata[pwfe_pkg::DUR_W-1:0];
        pwfe_pkg::REG_END:   cfg_nxt.end_duration   = pwdata[pwfe_pkg::DUR_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_duration <= pwfe_pkg::DUR_W'(50);
      cfg_r.long_duration  <= pwfe_pkg::DUR_W'(100);
      cfg_r.end_duration   <= pwfe_pkg::DUR_W'(400);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back: zero-extend the selected register
  always_comb begin
    unique case (reg_idx)
      pwfe_pkg::REG_SHORT: prdata = pwfe_pkg::APB_DW'(cfg_r.short_duration);
      pwfe_pkg::REG_LONG:  prdata = pwfe_pkg::APB_DW'(cfg_r.long_duration);
      pwfe_pkg::REG_END:   prdata = pwfe_pkg::APB_DW'(cfg_r.end_duration);
      default:             prdata = '0;
    endcase
  end

  // Front: accept the byte, compute parity, queue the command
  pwfe_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_data_byte      (in_data_byte),
    .in_first_of_frame (in_first_of_frame),
    .in_last_of_frame  (in_last_of_frame),
    .cmd_valid         (cmd_valid),
    .cmd_data          (cmd_data),
    .cmd_pop           (cmd_pop)
  );

  // Back: walk start, preamble, bits, parity, end; one per cycle while output has room
  pwfe_back #(
    .PREAMBLE_PAIRS (PREAMBLE_PAIRS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign out_duration    = res.duration;
  assign out_last_of_run = res.last_of_run;
  assign out_frame_end   = res.frame_end;

endmodule
